// ===== hw/rtl/mgd_pkg.sv =====
// Shared types and constants for the motor gear duty block.
// No dependencies; imported by motor_gear_duty_with_kick_start.
package mgd_pkg;

	localparam int DUTY_W     = 10;
	localparam int GEAR_W     = 8;
	localparam int TICKS_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	localparam logic [DUTY_W-1:0] DUTY_LIMIT = 10'd1000;
	localparam logic [DUTY_W-1:0] FLOOR_MIN  = 10'd100;

	localparam int GEAR_COUNT_DEF = 50;

	localparam logic [DUTY_W-1:0]  FLOOR_RST      = 10'd280;
	localparam logic [DUTY_W-1:0]  CEILING_RST    = 10'd380;
	localparam logic [DUTY_W-1:0]  KICK_DUTY_RST  = 10'd600;
	localparam logic [TICKS_W-1:0] KICK_TICKS_RST = 8'd20;

	typedef enum logic [1:0] {
		KIND_GEAR = 2'd0,
		KIND_TICK = 2'd1,
		KIND_RAW  = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DUTY_FLOOR   = 2'd0,
		REG_DUTY_CEILING = 2'd1,
		REG_KICK_DUTY    = 2'd2,
		REG_KICK_TICKS   = 2'd3
	} cfg_reg_t;

	function automatic logic [DUTY_W-1:0] sat_duty(input logic [DUTY_W-1:0] v);
		return (v > DUTY_LIMIT) ? DUTY_LIMIT : v;
	endfunction

endpackage

// ===== hw/rtl/motor_gear_duty_with_kick_start.sv =====
// Motor duty controller: gear mapping, raw duty requests and a timed kick start.
// Depends on mgd_pkg for constants, the command kind enum and register indexes.
//
// Usage:
//   s_axis carries commands: tuser holds the kind (set gear, tick, set raw duty),
//   tdata holds the gear and the raw duty. Every accepted beat yields exactly one
//   m_axis beat with the duty now applied and whether the kick is still running.
//   cfg_we/cfg_index/cfg_data write the floor, ceiling, kick duty and kick length;
//   write them only while no command is in flight.
// Throughput:
//   One command is taken every cycle while m_axis_tready is high: the first stage
//   forms the interpolation product, the second divides it by the gear span
//   through a reciprocal multiply, the third updates the duty, goal and kick
//   countdown and loads the output register.
// Reset:
//   Applied duty, goal duty and kick countdown clear to zero, the registers load
//   their default values, and the pipeline empties.
// Stall:
//   While m_axis_tready is low the result holds; the pipeline keeps filling and
//   s_axis_tready drops once all three stages hold a beat.
module motor_gear_duty_with_kick_start
	import mgd_pkg::*;
#(
	parameter int GEAR_COUNT = GEAR_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// commands
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [23:0]           s_axis_tdata,  // [7:0] gear, [17:8] raw_duty, rest zero
	input  logic [1:0]            s_axis_tuser,  // [1:0] kind
	// results
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [15:0]           m_axis_tdata   // [9:0] duty, [10] kick_active, rest zero
);

	localparam int SPAN   = GEAR_COUNT - 1;
	localparam int SPAN_W = (GEAR_COUNT > 2) ? $clog2(GEAR_COUNT) : 1;
	localparam int NUM_W  = DUTY_W + SPAN_W + 1;
	localparam int SHIFT  = NUM_W + SPAN_W;
	localparam int PROD_W = NUM_W + SHIFT + 1;
	localparam logic [SHIFT:0] RECIP = (SHIFT+1)'(((64'd1 << SHIFT) + SPAN - 1) / SPAN);
	localparam logic [NUM_W-1:0]  HALF_SPAN = NUM_W'(SPAN / 2);
	localparam logic [GEAR_W-1:0] GEAR_MAX  = GEAR_W'(GEAR_COUNT);

	// configuration registers
	logic [DUTY_W-1:0]  duty_floor_q, duty_ceiling_q, kick_duty_q;
	logic [TICKS_W-1:0] kick_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_floor_q   <= FLOOR_RST;
			duty_ceiling_q <= CEILING_RST;
			kick_duty_q    <= KICK_DUTY_RST;
			kick_ticks_q   <= KICK_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_DUTY_FLOOR:   duty_floor_q   <= cfg_data;
				REG_DUTY_CEILING: duty_ceiling_q <= cfg_data;
				REG_KICK_DUTY:    kick_duty_q    <= cfg_data;
				REG_KICK_TICKS:   kick_ticks_q   <= cfg_data[TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline handshake
	logic v_s1, v_s2, out_v_q;
	logic out_rdy, s2_rdy, s1_rdy, upd;

	assign out_rdy       = !out_v_q || m_axis_tready;
	assign s2_rdy        = !v_s2 || out_rdy;
	assign s1_rdy        = !v_s1 || s2_rdy;
	assign s_axis_tready = s1_rdy;
	assign upd           = v_s2 && out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_rdy)
				v_s1 <= s_axis_tvalid;
			if (s2_rdy)
				v_s2 <= v_s1;
			if (out_rdy)
				out_v_q <= v_s2;
		end
	end

	// stage 0: effective floor/ceiling and interpolation numerator
	logic [GEAR_W-1:0] in_gear, gear_c;
	logic [DUTY_W-1:0] in_raw, ceil_v, floor_c, floor_v, diff;
	logic [SPAN_W-1:0] gm1;
	logic [NUM_W-1:0]  num;
	logic              flat;

	assign in_gear = s_axis_tdata[7:0];
	assign in_raw  = s_axis_tdata[17:8];

	always_comb begin
		ceil_v  = sat_duty(duty_ceiling_q);
		floor_c = (duty_floor_q < FLOOR_MIN) ? FLOOR_MIN : duty_floor_q;
		floor_v = (floor_c > ceil_v) ? ceil_v : floor_c;
		flat    = (ceil_v <= floor_v);
		diff    = ceil_v - floor_v;
		gear_c  = (in_gear > GEAR_MAX) ? GEAR_MAX : in_gear;
		gm1     = SPAN_W'(gear_c - GEAR_W'(1));
		num     = NUM_W'(diff) * NUM_W'(gm1) + HALF_SPAN;
	end

	kind_t             kind_s1, kind_s2;
	logic              gear_zero_s1, flat_s1;
	logic [DUTY_W-1:0] floor_s1, raw_s1, d_s2;
	logic [NUM_W-1:0]  num_s1;

	always_ff @(posedge clk) begin
		if (s1_rdy) begin
			kind_s1      <= kind_t'(s_axis_tuser);
			gear_zero_s1 <= (in_gear == '0);
			flat_s1      <= flat;
			floor_s1     <= floor_v;
			raw_s1       <= sat_duty(in_raw);
			num_s1       <= num;
		end
	end

	// stage 1: divide by the span through a reciprocal multiply
	logic [PROD_W-1:0] prod;
	logic [DUTY_W-1:0] quot, d_next;

	assign prod = PROD_W'(num_s1) * PROD_W'(RECIP);
	assign quot = prod[SHIFT +: DUTY_W];

	always_comb begin
		case (kind_s1)
			KIND_GEAR: begin
				if (gear_zero_s1)
					d_next = '0;
				else if (flat_s1)
					d_next = floor_s1;
				else
					d_next = floor_s1 + quot;
			end
			KIND_RAW: d_next = raw_s1;
			default:  d_next = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s2_rdy) begin
			kind_s2 <= kind_s1;
			d_s2    <= d_next;
		end
	end

	// stage 2: state update
	logic [DUTY_W-1:0]  applied_q, goal_q, applied_nx, goal_nx;
	logic [TICKS_W-1:0] kick_q, kick_nx;

	always_comb begin
		applied_nx = applied_q;
		goal_nx    = goal_q;
		kick_nx    = kick_q;
		case (kind_s2)
			KIND_GEAR: begin
				goal_nx = d_s2;
				if (d_s2 == '0) begin
					kick_nx    = '0;
					applied_nx = '0;
				end else if (applied_q == '0) begin
					applied_nx = sat_duty(kick_duty_q);
					kick_nx    = (kick_ticks_q == '0) ? TICKS_W'(1) : kick_ticks_q;
				end else begin
					applied_nx = d_s2;
				end
			end
			KIND_TICK: begin
				if (kick_q != '0) begin
					kick_nx = kick_q - TICKS_W'(1);
					// countdown ends: drop to the goal
					if (kick_q == TICKS_W'(1))
						applied_nx = goal_q;
				end
			end
			KIND_RAW: begin
				kick_nx    = '0;
				goal_nx    = d_s2;
				applied_nx = d_s2;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			applied_q <= '0;
			goal_q    <= '0;
			kick_q    <= '0;
		end else if (upd) begin
			applied_q <= applied_nx;
			goal_q    <= goal_nx;
			kick_q    <= kick_nx;
		end
	end

	logic [DUTY_W-1:0] out_duty_q;
	logic              out_kick_q;

	always_ff @(posedge clk) begin
		if (upd) begin
			out_duty_q <= applied_nx;
			out_kick_q <= (kick_nx != '0);
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {5'd0, out_kick_q, out_duty_q};

	// checks
	a_kick_end_goal: assert property (@(posedge clk) disable iff (!arst_n)
		(upd && kind_s2 == KIND_TICK && kick_q == TICKS_W'(1)) |=> (applied_q == goal_q))
		else $error("kick end did not apply the goal duty");

	a_out_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		upd |=> (m_axis_tdata[9:0] == applied_q && m_axis_tdata[10] == (kick_q != '0)))
		else $error("result beat differs from updated state");

	a_kick_start_by_gear: assert property (@(posedge clk) disable iff (!arst_n)
		(kick_q != '0 && $past(kick_q) == '0) |-> $past(upd && kind_s2 == KIND_GEAR))
		else $error("kick started without a gear beat");

endmodule
